// File: rtl/i2a_pkg.sv
`default_nettype none

package i2a_pkg;

  // Default width of the signed input value.
  localparam int unsigned DEF_VALUE_WIDTH = 32;

  // Width of one output character.
  localparam int unsigned CHAR_W = 8;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;

  // ASCII codes used by the back part.
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  // Conversion sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGIT
  } conv_state_t;

endpackage

`default_nettype wire

// File: rtl/i2a_front.sv
`default_nettype none

module i2a_front #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned TDATA_W     = 32
) (
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [TDATA_W-1:0]     in_tdata,
  output logic                        push_valid,
  input  wire logic                   push_ready,
  output logic [VALUE_WIDTH:0]        push_data
);

  logic [VALUE_WIDTH-1:0] raw;
  logic                   negative;
  logic [VALUE_WIDTH-1:0] magnitude;

  // Classify the value by its sign bit and form the magnitude. The most
  // negative value negates to itself, which read unsigned is exact.
  always_comb begin
    raw       = in_tdata[VALUE_WIDTH-1:0];
    negative  = raw[VALUE_WIDTH-1];
    magnitude = negative ? (~raw + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : raw;
  end

  // Items go straight into the queue; the queue sets the input ready.
  assign push_valid = in_tvalid;
  assign in_tready  = push_ready;
  assign push_data  = {negative, magnitude};

endmodule

`default_nettype wire

// File: rtl/i2a_queue.sv
`default_nettype none

module i2a_queue #(
  parameter int unsigned DATA_W = 33,
  parameter int unsigned DEPTH  = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output logic [DATA_W-1:0]      pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count updates, wrapping at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/i2a_back.sv
`default_nettype none

module i2a_back #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           pop_valid,
  output logic                                pop_ready,
  input  wire logic [VALUE_WIDTH:0]           pop_data,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [i2a_pkg::CHAR_W-1:0]          out_tdata,
  output logic                                out_tlast
);

  import i2a_pkg::*;

  // Decimal digits needed for VALUE_WIDTH bits: floor(W * log10(2)) + 1.
  localparam int unsigned NDIG  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned BCD_W = 4 * NDIG;
  localparam int unsigned IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);

  conv_state_t            state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic                   neg_r, neg_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic                   oval_r, oval_nxt;
  logic [CHAR_W-1:0]      ochar_r, ochar_nxt;
  logic                   olast_r, olast_nxt;

  logic [BCD_W-1:0]       bcd_adj;
  logic [IDX_W-1:0]       msd_idx;
  logic [3:0]             cur_digit;
  logic                   slot_free;

  // Add three to every BCD digit of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                     : bcd_r[4*i +: 4];
    end
  end

  // Position of the most significant nonzero digit; zero gives position 0.
  always_comb begin
    msd_idx = '0;
    for (int i = 1; i < NDIG; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) begin
        msd_idx = IDX_W'(i);
      end
    end
  end

  assign cur_digit = bcd_r[4*idx_r +: 4];
  assign slot_free = !oval_r || out_tready;
  assign pop_ready = (state_r == ST_IDLE);

  // Sequencer: load, shift-and-adjust, optional sign, then digits.
  always_comb begin
    state_nxt = state_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    oval_nxt  = oval_r && !out_tready;
    ochar_nxt = ochar_r;
    olast_nxt = olast_r;
    case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          neg_nxt   = pop_data[VALUE_WIDTH];
          bin_nxt   = pop_data[VALUE_WIDTH-1:0];
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        {bcd_nxt, bin_nxt} = {bcd_adj, bin_r} << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(VALUE_WIDTH - 1)) begin
          state_nxt = ST_SIGN;
        end
      end
      ST_SIGN: begin
        idx_nxt = msd_idx;
        if (!neg_r) begin
          state_nxt = ST_DIGIT;
        end else if (slot_free) begin
          oval_nxt  = 1'b1;
          ochar_nxt = ASCII_MINUS;
          olast_nxt = 1'b0;
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (slot_free) begin
          oval_nxt  = 1'b1;
          ochar_nxt = ASCII_ZERO + {{(CHAR_W-4){1'b0}}, cur_digit};
          olast_nxt = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    bin_r   <= bin_nxt;
    bcd_r   <= bcd_nxt;
    neg_r   <= neg_nxt;
    cnt_r   <= cnt_nxt;
    idx_r   <= idx_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = ochar_r;
  assign out_tlast  = olast_r;

endmodule

`default_nettype wire

// File: rtl/signed_int_to_decimal_ascii_core.sv
// Channel | Direction | Ports                        | Payload
// in      | slave     | in_tvalid/in_tready/in_tdata | tdata: value (VALUE_WIDTH, signed)
// out     | master    | out_tvalid/out_tready/       | tdata: character (8); tlast: last
//         |           | out_tdata/out_tlast          |
//
// An item passes through a load state, the shift-and-adjust loop (the binary
// to BCD loop), a sign state, and a digit state that emits its digits in turn.
// A two-entry queue holds accepted values while the back part works.
// Reset (rst_n, synchronous, active low) empties the queue and the output.
// A stalled output register holds the back part; the input stalls only when
// the queue is full.
`default_nettype none

module signed_int_to_decimal_ascii_core #(
  parameter int unsigned VALUE_WIDTH = i2a_pkg::DEF_VALUE_WIDTH,
  parameter int unsigned TDATA_W     = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [TDATA_W-1:0]            in_tdata,   // value
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [i2a_pkg::CHAR_W-1:0]         out_tdata,  // character
  output logic                               out_tlast
);

  import i2a_pkg::*;

  logic                 push_valid;
  logic                 push_ready;
  logic [VALUE_WIDTH:0] push_data;
  logic                 pop_valid;
  logic                 pop_ready;
  logic [VALUE_WIDTH:0] pop_data;

  // Front part: sign and magnitude.
  i2a_front #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .TDATA_W     (TDATA_W)
  ) u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Queue between the two parts.
  i2a_queue #(
    .DATA_W (VALUE_WIDTH + 1),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back part: decimal conversion and character output.
  i2a_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
